@@ src/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Types and constants shared by the TCP SYN probe builder modules.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned SumW     = 20;
  localparam int unsigned NumWords = 10;

  // Fixed header words and fields
  localparam logic [31:0] IP_VER_IHL_TOS_LEN = 32'h4500_0028;
  localparam logic [15:0] IP_DF_FLAG         = 16'h4000;
  localparam logic [7:0]  PROTO_TCP          = 8'h06;
  localparam logic [15:0] TCP_HDR_LEN        = 16'h0014;
  localparam logic [15:0] TCP_OFF_FLAGS      = 16'h5002;

  // Constant terms of the two checksums
  localparam logic [SumW-1:0] IP_CONST_SUM  =
    SumW'(IP_VER_IHL_TOS_LEN[31:16]) + SumW'(IP_VER_IHL_TOS_LEN[15:0]) + SumW'(IP_DF_FLAG);
  localparam logic [SumW-1:0] TCP_CONST_SUM =
    SumW'(PROTO_TCP) + SumW'(TCP_HDR_LEN) + SumW'(TCP_OFF_FLAGS);

  localparam logic [3:0] WORD_FIRST = 4'd0;
  localparam logic [3:0] WORD_LAST  = 4'(NumWords - 1);

  // Reset values of the registers
  localparam logic [31:0] RST_SRC_ADDR = 32'd0;
  localparam logic [15:0] RST_SRC_PORT = 16'd46156;
  localparam logic [31:0] RST_SEQ      = 32'd1105024978;
  localparam logic [15:0] RST_WINDOW   = 16'd14600;
  localparam logic [7:0]  RST_TTL      = 8'd64;
  localparam logic [15:0] RST_IDENT    = 16'd46156;

  typedef enum logic [2:0] {
    REG_SRC_ADDR = 3'd0,
    REG_SRC_PORT = 3'd1,
    REG_SEQ      = 3'd2,
    REG_WINDOW   = 3'd3,
    REG_TTL      = 3'd4,
    REG_IDENT    = 3'd5
  } tsp_reg_e;

  typedef struct packed {
    logic [31:0] source_addr;
    logic [15:0] source_port;
    logic [31:0] initial_sequence;
    logic [15:0] window_size;
    logic [7:0]  time_to_live;
    logic [15:0] ip_ident;
  } tsp_cfg_t;

  // One classified probe, as queued between front and back
  typedef struct packed {
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } tsp_rec_t;

  // Fold a 20-bit ones'-complement sum and invert it
  function automatic logic [15:0] fold_csum(input logic [SumW-1:0] sum);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = 17'(sum[15:0]) + 17'(sum[SumW-1:16]);
    f2 = 17'(f1[15:0]) + 17'(f1[16]);
    return ~f2[15:0];
  endfunction

endpackage

@@ src/tsp_regs.sv @@
// ----------------------------------------------------------------------------
// tsp_regs
// APB-style register file holding the probe configuration.
// ----------------------------------------------------------------------------
module tsp_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsp_pkg::AddrW-1:0] paddr,
  input  logic [tsp_pkg::DataW-1:0] pwdata,
  output logic [tsp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output tsp_pkg::tsp_cfg_t         cfg_o
);
  import tsp_pkg::*;

  tsp_cfg_t cfg_q, cfg_d;
  tsp_reg_e sel;
  logic     wr_en;

  assign sel    = tsp_reg_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_SRC_ADDR: cfg_d.source_addr      = pwdata;
        REG_SRC_PORT: cfg_d.source_port      = pwdata[15:0];
        REG_SEQ:      cfg_d.initial_sequence = pwdata;
        REG_WINDOW:   cfg_d.window_size      = pwdata[15:0];
        REG_TTL:      cfg_d.time_to_live     = pwdata[7:0];
        REG_IDENT:    cfg_d.ip_ident         = pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SRC_ADDR: prdata = cfg_q.source_addr;
      REG_SRC_PORT: prdata = {16'd0, cfg_q.source_port};
      REG_SEQ:      prdata = cfg_q.initial_sequence;
      REG_WINDOW:   prdata = {16'd0, cfg_q.window_size};
      REG_TTL:      prdata = {24'd0, cfg_q.time_to_live};
      REG_IDENT:    prdata = {16'd0, cfg_q.ip_ident};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_addr      <= RST_SRC_ADDR;
      cfg_q.source_port      <= RST_SRC_PORT;
      cfg_q.initial_sequence <= RST_SEQ;
      cfg_q.window_size      <= RST_WINDOW;
      cfg_q.time_to_live     <= RST_TTL;
      cfg_q.ip_ident         <= RST_IDENT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/tsp_front.sv @@
// ----------------------------------------------------------------------------
// tsp_front
// Accepts probe requests and computes both header checksums in two stages.
// ----------------------------------------------------------------------------
module tsp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsp_pkg::tsp_cfg_t  cfg_i,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        dest_addr_i,
  input  logic [15:0]        dest_port_i,
  output logic               rec_valid_o,
  input  logic               rec_ready_i,
  output tsp_pkg::tsp_rec_t  rec_o
);
  import tsp_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic              s2_valid_q, s2_valid_d;
  logic [31:0]       s1_daddr_q, s2_daddr_q;
  logic [15:0]       s1_dport_q, s2_dport_q;
  logic [SumW-1:0]   ip_sum_q, ip_sum_d;
  logic [SumW-1:0]   tcp_sum_q, tcp_sum_d;
  logic              s1_ready, s2_ready, s1_load, s2_load;

  assign s2_ready = !s2_valid_q || rec_ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign full     = !s1_ready;
  assign s1_load  = push && s1_ready;
  assign s2_load  = s1_valid_q && s2_ready;

  assign s1_valid_d = s1_load  ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s2_load  ? 1'b1 : (rec_ready_i ? 1'b0 : s2_valid_q);

  always_comb begin
    ip_sum_d = IP_CONST_SUM
             + SumW'(cfg_i.ip_ident)
             + SumW'({cfg_i.time_to_live, PROTO_TCP})
             + SumW'(cfg_i.source_addr[31:16]) + SumW'(cfg_i.source_addr[15:0])
             + SumW'(s1_daddr_q[31:16]) + SumW'(s1_daddr_q[15:0]);
    tcp_sum_d = TCP_CONST_SUM
              + SumW'(cfg_i.source_addr[31:16]) + SumW'(cfg_i.source_addr[15:0])
              + SumW'(s1_daddr_q[31:16]) + SumW'(s1_daddr_q[15:0])
              + SumW'(cfg_i.source_port) + SumW'(s1_dport_q)
              + SumW'(cfg_i.initial_sequence[31:16])
              + SumW'(cfg_i.initial_sequence[15:0])
              + SumW'(cfg_i.window_size);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_daddr_q <= dest_addr_i;
      s1_dport_q <= dest_port_i;
    end
    if (s2_load) begin
      s2_daddr_q <= s1_daddr_q;
      s2_dport_q <= s1_dport_q;
      ip_sum_q   <= ip_sum_d;
      tcp_sum_q  <= tcp_sum_d;
    end
  end

  assign rec_valid_o       = s2_valid_q;
  assign rec_o.dest_addr   = s2_daddr_q;
  assign rec_o.dest_port   = s2_dport_q;
  assign rec_o.ip_csum     = fold_csum(ip_sum_q);
  assign rec_o.tcp_csum    = fold_csum(tcp_sum_q);

endmodule

@@ src/tsp_fifo.sv @@
// ----------------------------------------------------------------------------
// tsp_fifo
// Short queue of classified probes between front and back.
// ----------------------------------------------------------------------------
module tsp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  tsp_pkg::tsp_rec_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_pop_i,
  output tsp_pkg::tsp_rec_t rd_data_o
);
  import tsp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  tsp_rec_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    if (!do_wr && do_rd) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

@@ src/tsp_back.sv @@
// ----------------------------------------------------------------------------
// tsp_back
// Serializes one queued probe into ten datagram words through an output register.
// ----------------------------------------------------------------------------
module tsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsp_pkg::tsp_cfg_t cfg_i,
  input  logic              rec_valid_i,
  output logic              rec_pop_o,
  input  tsp_pkg::tsp_rec_t rec_i,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       header_word_o,
  output logic [3:0]        word_index_o,
  output logic              last_word_o
);
  import tsp_pkg::*;

  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q, word_d;
  logic [3:0]  idx_q;
  logic        last_q;
  logic        load;
  logic        is_last;

  assign is_last   = (cnt_q == WORD_LAST);
  assign load      = rec_valid_i && (!out_valid_q || pop);
  assign rec_pop_o = load && is_last;

  always_comb begin
    case (cnt_q)
      4'd0:    word_d = IP_VER_IHL_TOS_LEN;
      4'd1:    word_d = {cfg_i.ip_ident, IP_DF_FLAG};
      4'd2:    word_d = {cfg_i.time_to_live, PROTO_TCP, rec_i.ip_csum};
      4'd3:    word_d = cfg_i.source_addr;
      4'd4:    word_d = rec_i.dest_addr;
      4'd5:    word_d = {cfg_i.source_port, rec_i.dest_port};
      4'd6:    word_d = cfg_i.initial_sequence;
      4'd8:    word_d = {TCP_OFF_FLAGS, cfg_i.window_size};
      4'd9:    word_d = {rec_i.tcp_csum, 16'd0};
      default: word_d = '0;
    endcase
  end

  assign cnt_d       = load ? (is_last ? WORD_FIRST : cnt_q + 1'b1) : cnt_q;
  assign out_valid_d = load ? 1'b1 : (pop ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= WORD_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      idx_q  <= cnt_q;
      last_q <= is_last;
    end
  end

  assign empty         = !out_valid_q;
  assign header_word_o = word_q;
  assign word_index_o  = idx_q;
  assign last_word_o   = last_q;

endmodule

@@ src/tcp_syn_probe_builder.sv @@
// ----------------------------------------------------------------------------
// tcp_syn_probe_builder
// Builds a 40-byte IPv4+TCP SYN datagram per probe as ten 32-bit words.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the front stages, the queue and the output
// register before its first word shows. Output: one word per cycle, back to
// back while pop is high and a probe is queued; new requests queue up meanwhile.
// Reset: asynchronous, clears all queues and valids and loads the register
// defaults; no clearing pass.
module tcp_syn_probe_builder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsp_pkg::AddrW-1:0] paddr,
  input  logic [tsp_pkg::DataW-1:0] pwdata,
  output logic [tsp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      push,
  output logic                      full,
  input  logic [31:0]               dest_addr_i,
  input  logic [15:0]               dest_port_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [31:0]               header_word_o,
  output logic [3:0]                word_index_o,
  output logic                      last_word_o
);
  import tsp_pkg::*;

  tsp_cfg_t cfg;
  tsp_rec_t front_rec, back_rec;
  logic     front_valid, front_ready, back_valid, back_pop;

  tsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push        (push),
    .full        (full),
    .dest_addr_i (dest_addr_i),
    .dest_port_i (dest_port_i),
    .rec_valid_o (front_valid),
    .rec_ready_i (front_ready),
    .rec_o       (front_rec)
  );

  tsp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_rec),
    .rd_valid_o (back_valid),
    .rd_pop_i   (back_pop),
    .rd_data_o  (back_rec)
  );

  tsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .rec_valid_i   (back_valid),
    .rec_pop_o     (back_pop),
    .rec_i         (back_rec),
    .empty         (empty),
    .pop           (pop),
    .header_word_o (header_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

@@ src/tsp_checker.sv @@
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks on the result stream of the probe builder.
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] header_word_o,
  input logic [3:0]  word_index_o,
  input logic        last_word_o
);
  import tsp_pkg::*;

  logic [3:0] exp_idx_q;

  // Track the index the next transferred word must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= WORD_FIRST;
    end else if (pop && !empty) begin
      exp_idx_q <= (exp_idx_q == WORD_LAST) ? WORD_FIRST : exp_idx_q + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(header_word_o) && $stable(word_index_o)))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (word_index_o == exp_idx_q))
    else $error("word index out of sequence");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_word_o == (word_index_o == WORD_LAST)))
    else $error("last flag does not match word index");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && word_index_o == WORD_FIRST) |-> (header_word_o == IP_VER_IHL_TOS_LEN))
    else $error("first word is not the fixed IP header word");

endmodule

bind tcp_syn_probe_builder tsp_checker u_tsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .header_word_o (header_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);

@@ tb/sv/tcp_syn_probe_builder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_syn_probe_builder_tb
// Programs the probe registers over APB, pushes probe requests and checks
// every datagram word popped from the block against a local SYN builder.
// Covers field extremes, zero checksums, truncated register writes, writes
// to an unused address and random stalls on both queue sides.
// ----------------------------------------------------------------------------
module tcp_syn_probe_builder_tb;

  localparam int unsigned RegAddrW   = tsp_pkg::AddrW;
  localparam int unsigned DgramWords = 10;
  localparam int unsigned NumRegs    = 6;
  localparam int unsigned UnusedReg  = 6;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned CycleLimit = 300000;

  // Fixed parts of the IPv4 and TCP headers
  localparam logic [31:0] IpVerLen  = 32'h4500_0028;
  localparam logic [15:0] DfFlag    = 16'h4000;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [15:0] TcpLen    = 16'd20;
  localparam logic [15:0] TcpOffSyn = 16'h5002;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  index;
    logic        last;
  } probe_word_t;

  typedef logic [DgramWords-1:0][31:0] dgram_t;

  class probe_scoreboard;
    tsp_pkg::tsp_cfg_t cfg;
    probe_word_t       expected_words[$];
    int unsigned       mismatches;

    function new();
      cfg.source_addr      = 32'd0;
      cfg.source_port      = 16'd46156;
      cfg.initial_sequence = 32'd1105024978;
      cfg.window_size      = 16'd14600;
      cfg.time_to_live     = 8'd64;
      cfg.ip_ident         = 16'd46156;
      mismatches           = 0;
    endfunction

    function void set_reg(input int unsigned idx, input logic [31:0] value);
      case (idx)
        tsp_pkg::REG_SRC_ADDR: cfg.source_addr      = value;
        tsp_pkg::REG_SRC_PORT: cfg.source_port      = value[15:0];
        tsp_pkg::REG_SEQ:      cfg.initial_sequence = value;
        tsp_pkg::REG_WINDOW:   cfg.window_size      = value[15:0];
        tsp_pkg::REG_TTL:      cfg.time_to_live     = value[7:0];
        tsp_pkg::REG_IDENT:    cfg.ip_ident         = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(input int unsigned idx);
      case (idx)
        tsp_pkg::REG_SRC_ADDR: return cfg.source_addr;
        tsp_pkg::REG_SRC_PORT: return {16'h0000, cfg.source_port};
        tsp_pkg::REG_SEQ:      return cfg.initial_sequence;
        tsp_pkg::REG_WINDOW:   return {16'h0000, cfg.window_size};
        tsp_pkg::REG_TTL:      return {24'h000000, cfg.time_to_live};
        tsp_pkg::REG_IDENT:    return {16'h0000, cfg.ip_ident};
        default:               return 32'h0000_0000;
      endcase
    endfunction

    // Fold carries back into the low half and invert
    function logic [15:0] fold_inv(input logic [31:0] acc);
      while (acc[31:16] != 16'h0000)
        acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
      return ~acc[15:0];
    endfunction

    function dgram_t datagram(input logic [31:0] daddr, input logic [15:0] dport);
      dgram_t      w;
      logic [31:0] acc;
      w[0] = IpVerLen;
      w[1] = {cfg.ip_ident, DfFlag};
      w[2] = {cfg.time_to_live, ProtoTcp, 16'h0000};
      w[3] = cfg.source_addr;
      w[4] = daddr;
      w[5] = {cfg.source_port, dport};
      w[6] = cfg.initial_sequence;
      w[7] = 32'h0000_0000;
      w[8] = {TcpOffSyn, cfg.window_size};
      w[9] = 32'h0000_0000;
      acc = 32'h0000_0000;
      for (int k = 0; k < 5; k++)
        acc = acc + w[k][31:16] + w[k][15:0];
      w[2][15:0] = fold_inv(acc);
      // pseudo-header: source, destination, protocol, TCP length
      acc = 32'h0000_0000 + cfg.source_addr[31:16] + cfg.source_addr[15:0] +
            daddr[31:16] + daddr[15:0] + ProtoTcp + TcpLen;
      for (int k = 5; k < 10; k++)
        acc = acc + w[k][31:16] + w[k][15:0];
      w[9][31:16] = fold_inv(acc);
      return w;
    endfunction

    function void note_probe(input logic [31:0] daddr, input logic [15:0] dport);
      dgram_t      w;
      probe_word_t pw;
      w = datagram(daddr, dport);
      for (int k = 0; k < DgramWords; k++) begin
        pw.word  = w[k];
        pw.index = 4'(k);
        pw.last  = (k == DgramWords - 1);
        expected_words.push_back(pw);
      end
    endfunction

    function void check_word(input logic [31:0] word, input logic [3:0] index,
                             input logic last);
      probe_word_t pw;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected word %h index %0d last %0d", word, index, last);
        return;
      end
      pw = expected_words.pop_front();
      if (pw.word !== word || pw.index !== index || pw.last !== last) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("word mismatch: expected %h idx %0d last %0d, got %h idx %0d last %0d",
                   pw.word, pw.index, pw.last, word, index, last);
      end
    endfunction

    function void check_reg(input int unsigned idx, input logic [31:0] got);
      if (got !== reg_value(idx)) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("register %0d readback: expected %h, got %h", idx, reg_value(idx), got);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [RegAddrW-1:0] paddr       = '0;
  logic [31:0]         pwdata      = 32'h0000_0000;
  logic [31:0]         prdata;
  logic                pready;
  logic                push        = 1'b0;
  logic                full;
  logic [31:0]         dest_addr_i = 32'h0000_0000;
  logic [15:0]         dest_port_i = 16'h0000;
  logic                empty;
  logic                pop         = 1'b0;
  logic [31:0]         header_word_o;
  logic [3:0]          word_index_o;
  logic                last_word_o;

  probe_scoreboard sb = new();
  bit              push_burst = 1'b0;
  bit              pop_burst  = 1'b0;

  tcp_syn_probe_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .dest_addr_i   (dest_addr_i),
    .dest_port_i   (dest_port_i),
    .empty         (empty),
    .pop           (pop),
    .header_word_o (header_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tcp_syn_probe_builder test failed");
    $finish;
  end

  // Setup and access cycle for the write, then read the register back unless the address is unused
  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegAddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx < NumRegs) begin
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      sb.check_reg(idx, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic program_all(input logic [31:0] saddr, input logic [31:0] sport,
                             input logic [31:0] seq, input logic [31:0] win,
                             input logic [31:0] ttl, input logic [31:0] ident);
    write_reg(tsp_pkg::REG_SRC_ADDR, saddr);
    write_reg(tsp_pkg::REG_SRC_PORT, sport);
    write_reg(tsp_pkg::REG_SEQ, seq);
    write_reg(tsp_pkg::REG_WINDOW, win);
    write_reg(tsp_pkg::REG_TTL, ttl);
    write_reg(tsp_pkg::REG_IDENT, ident);
  endtask

  // Leaves push high after the transfer; the caller drops it at the end
  task automatic send_probe(input logic [31:0] daddr, input logic [15:0] dport);
    int unsigned gap;
    if ($urandom_range(0, 14) == 0)
      push_burst = !push_burst;
    gap = push_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    dest_addr_i <= daddr;
    dest_port_i <= dport;
    do @(posedge clk_i); while (full);
    sb.note_probe(daddr, dport);
  endtask

  // Search one 16-bit field so that the IP or the TCP checksum comes out zero
  task automatic send_zero_csum(input bit ip_side);
    logic [31:0] daddr;
    logic [15:0] dport;
    dgram_t      w;
    daddr = $urandom;
    dport = 16'($urandom_range(0, 65535));
    for (int v = 0; v < 65536; v++) begin
      if (ip_side)
        daddr[15:0] = v[15:0];
      else
        dport = v[15:0];
      w = sb.datagram(daddr, dport);
      if ((ip_side ? w[2][15:0] : w[9][31:16]) == 16'h0000)
        break;
    end
    send_probe(daddr, dport);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] mask);
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // Result side: random stalls with bursts of back-to-back pops
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0)
        pop_burst = !pop_burst;
      gap = pop_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_word(header_word_o, word_index_o, last_word_o);
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: readback first, then field extremes and zero checksums
    for (int r = 0; r < NumRegs; r++) begin
      psel   <= 1'b1;
      pwrite <= 1'b0;
      paddr  <= RegAddrW'(r * 4);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      sb.check_reg(r, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
    send_probe(32'h0000_0000, 16'h0000);
    send_probe(32'hffff_ffff, 16'hffff);
    send_probe(32'h8000_0000, 16'h8000);
    send_probe(32'h0000_0001, 16'h0001);
    send_probe(32'haaaa_aaaa, 16'h5555);
    send_probe(32'h5555_5555, 16'haaaa);
    send_probe(32'h0a00_0001, 16'd80);
    send_probe(32'hc0a8_0101, 16'd443);
    send_zero_csum(1'b1);
    send_zero_csum(1'b0);
    wait_drained();

    // all registers zero; the unused address must not disturb anything
    program_all('0, '0, '0, '0, '0, '0);
    write_reg(UnusedReg, 32'hffff_ffff);
    send_probe(32'h0000_0000, 16'h0000);
    send_probe(32'hffff_ffff, 16'hffff);
    send_zero_csum(1'b1);
    wait_drained();

    // all ones, wider than the narrow registers
    program_all('1, '1, '1, '1, '1, '1);
    send_probe(32'h0000_0000, 16'h0000);
    send_probe(32'hffff_ffff, 16'hffff);
    send_zero_csum(1'b0);
    send_zero_csum(1'b1);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      program_all(pick_value('1), pick_value('1), pick_value('1),
                  pick_value('1), pick_value('1), pick_value('1));
      if ($urandom_range(0, 1) == 1)
        write_reg(UnusedReg, $urandom);
      for (int n = 0; n < 19; n++)
        send_probe(pick_value('1), 16'(pick_value(32'h0000_ffff)));
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0)
      $display("tcp_syn_probe_builder test passed");
    else
      $display("tcp_syn_probe_builder test failed");
    $finish;
  end

endmodule
